// File: rtl/max_priority_ready_queue_core_defines.svh
// Assertion macros used by the queue core.
`ifndef MAX_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH
`define MAX_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define MPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition in one cycle brings a consequence in the next.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPQ_ASSERT(label, clk, rst_n, prop, msg)
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int HANDLE_W        = 8;
  localparam int PRIO_W          = 8;
  localparam int OCC_W           = 5;

  typedef enum logic {
    REQ_ENQUEUE = 1'b0,
    REQ_DEQUEUE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    req_t                req_type;
    logic [HANDLE_W-1:0] proc_handle;
    logic [PRIO_W-1:0]   proc_priority;
  } in_beat_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] out_handle;
    logic [PRIO_W-1:0]   out_priority;
    logic [OCC_W-1:0]    occupancy;
  } out_beat_t;

  // One stored queue entry.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  // Memory port enables.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // Best-entry tracker controls.
  typedef struct packed {
    logic clear;
    logic sample;
  } best_ctl_t;

endpackage

`default_nettype wire

// File: rtl/mpq_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_store #(
  parameter int DEPTH = mpq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire mpq_pkg::mem_ctl_t mem_ctl,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire mpq_pkg::entry_t  wr_data,
  output mpq_pkg::entry_t       rd_data
);
  import mpq_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  // Write one entry per cycle.
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Register the read data.
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/mpq_best_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_best_unit #(
  parameter int AW = 4
) (
  input  wire logic              clk,
  input  wire mpq_pkg::best_ctl_t best_ctl,
  input  wire logic [AW-1:0]     cand_idx,
  input  wire mpq_pkg::entry_t   cand,
  output logic [AW-1:0]          best_idx,
  output mpq_pkg::entry_t        best_ent
);
  import mpq_pkg::*;

  logic [AW-1:0] best_idx_r;
  entry_t        best_ent_r;

  // Keep the highest priority seen; ties go to the later entry.
  always_ff @(posedge clk) begin
    if (best_ctl.clear) begin
      best_idx_r <= '0;
      best_ent_r <= '0;
    end else if (best_ctl.sample && (cand.prio >= best_ent_r.prio)) begin
      best_idx_r <= cand_idx;
      best_ent_r <= cand;
    end
  end

  assign best_idx = best_idx_r;
  assign best_ent = best_ent_r;

endmodule

`default_nettype wire

// File: rtl/max_priority_ready_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "max_priority_ready_queue_core_defines.svh"

// Ready queue of up to QUEUE_DEPTH process handles, one request per beat.
// An enqueue appends at the tail, and its result goes out through the FINISH state.
// A dequeue with n entries held walks the entry memory twice: a scan of n
// reads through one shared priority comparator, then a shift of the
// n - 1 - b entries behind the winner at place b, one read and one write per
// cycle (none when the winner is the tail), and then the FINISH state hands
// the result over once the output register is free. Ties go to the entry
// nearest the tail.
// A dequeue on an empty queue reports empty and an enqueue into a full queue
// is dropped and reported. in_stall is high while a request is in work; a
// finished result waits in the output register and the next request is taken
// meanwhile.
module max_priority_ready_queue_core #(
  parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mpq_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mpq_pkg::out_beat_t      out_data
);
  import mpq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  out_beat_t     pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;
  logic          out_load;

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  best_ctl_t     best_ctl;
  logic [AW-1:0] best_idx;
  entry_t        best_ent;

  mpq_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  mpq_best_unit #(
    .AW (AW)
  ) u_best (
    .clk      (clk),
    .best_ctl (best_ctl),
    .cand_idx (rd_idx_r),
    .cand     (rd_data),
    .best_idx (best_idx),
    .best_ent (best_ent)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequence the request.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = ptr_r[AW-1:0];
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;
    mem_ctl       = '0;
    rd_addr       = ptr_r[AW-1:0];
    wr_addr       = count_r[AW-1:0];
    wr_data       = '{handle: in_data.proc_handle, prio: in_data.proc_priority};
    best_ctl      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pend_nxt = '{status: ST_ENQUEUED, out_handle: '0, out_priority: '0,
                       occupancy: OCC_W'(count_r)};
          state_nxt = S_FINISH;
          if (in_data.req_type == REQ_ENQUEUE) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              pend_nxt.status = ST_FULL;
            end else begin
              mem_ctl.wr_en      = 1'b1;
              count_nxt          = count_r + 1'b1;
              pend_nxt.occupancy = OCC_W'(count_r + 1'b1);
            end
          end else if (count_r == '0) begin
            pend_nxt.status = ST_EMPTY;
          end else begin
            ptr_nxt        = '0;
            best_ctl.clear = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Stream entries through the comparator.
        best_ctl.sample = rd_vld_r;
        if (ptr_r != count_r) begin
          mem_ctl.rd_en = 1'b1;
          rd_vld_nxt    = 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
        end else if (!rd_vld_r) begin
          ptr_nxt   = CW'(best_idx) + 1'b1;
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Move each later entry down one place.
        if (rd_vld_r) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = rd_idx_r - 1'b1;
          wr_data       = rd_data;
        end
        if (ptr_r != count_r) begin
          mem_ctl.rd_en = 1'b1;
          rd_vld_nxt    = 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
        end else if (!rd_vld_r) begin
          count_nxt = count_r - 1'b1;
          pend_nxt  = '{status: ST_DEQUEUED, out_handle: best_ent.handle,
                        out_priority: best_ent.prio,
                        occupancy: OCC_W'(count_r - 1'b1)};
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  `MPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(QUEUE_DEPTH), "count above depth")
  `MPQ_ASSERT(a_idle_no_read, clk, rst_n, (state_r == S_IDLE) |-> !rd_vld_r, "read left in flight")
  `MPQ_ASSERT(a_empty_status, clk, rst_n, (out_load && pend_r.status == ST_EMPTY) |-> (count_r == '0), "empty status with entries held")
  `MPQ_ASSERT(a_scan_idx, clk, rst_n, (state_r == S_SCAN && rd_vld_r) |-> (CW'(rd_idx_r) < count_r), "scan read beyond tail")
  `MPQ_ASSERT_NEXT(a_deq_shrinks, clk, rst_n, state_r == S_SHIFT && state_nxt == S_FINISH, count_r == $past(count_r) - 1'b1, "dequeue did not shrink count")

endmodule

`default_nettype wire
